// ===== design/tps_pkg.sv =====
// Package for the timed phase sequencer: item and result types,
// item and loop mode codes, register indexes and arithmetic widths.
// No dependencies.
`default_nettype none

package tps_pkg;

	// fixed field widths
	localparam int MODE_W   = 2;
	localparam int SLOT_W   = 4;
	localparam int DUR_W    = 16;
	localparam int RND_W    = 16;
	localparam int PHASE_W  = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	// remainder unit: bits retired per cycle
	localparam int DIGIT_W   = 4;
	localparam int DIV_STEPS = RND_W / DIGIT_W;

	// item modes
	localparam logic [MODE_W-1:0] MODE_TICK    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RESTART = 2'd2;

	// loop modes
	localparam logic [1:0] LOOP_INFINITE = 2'd0;
	localparam logic [1:0] LOOP_PINGPONG = 2'd1;
	localparam logic [1:0] LOOP_COUNTED  = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOOP_MODE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOOP_LIMIT  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_PHASE = 2'd3;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [SLOT_W-1:0] slot;
		logic [DUR_W-1:0]  min_ticks;
		logic [DUR_W-1:0]  max_ticks;
		logic [RND_W-1:0]  random_value;
	} tps_item_t;

	typedef struct packed {
		logic [PHASE_W-1:0] current_phase;
		logic               phase_changed;
		logic               halted;
	} tps_result_t;

endpackage

`default_nettype wire

// ===== design/timed_phase_sequencer_top.sv =====
// Timed phase sequencer: phase table, tick counting, loop modes and
// duration draw through an iterative remainder unit.
// Depends on tps_pkg.
// Steps: an item is captured in idle, applied in the execute step and handed
// over from the final step; an entered phase adds the table read and span steps,
// and a drawn duration adds the remainder unit's iterations, 4 bits a cycle.
// A new item is taken only once the last result has been handed over.
// Reset: asynchronous, active low; clears sequencer state and registers to
// their defaults; the phase table holds no defined contents until loaded.
`default_nettype none

module timed_phase_sequencer_top
	import tps_pkg::*;
#(
	parameter int MAX_PHASES = 16,
	parameter int TICK_BITS  = 16
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  item_valid,
	output logic                 item_stall,
	input  tps_item_t            item,
	output logic                 result_valid,
	input  wire                  result_stall,
	output tps_result_t          result,
	input  wire                  cfg_valid,
	output logic                 cfg_ready,
	input  wire [CFG_IDX_W-1:0]  cfg_index,
	input  wire [CFG_DAT_W-1:0]  cfg_data
);

	localparam int AW = $clog2(MAX_PHASES);
	localparam int CW = $clog2(MAX_PHASES + 1);
	localparam int DCW = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_READ = 3'd2;
	localparam logic [2:0] S_SPAN = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;

	logic [2:0]           state_q;
	tps_item_t            item_q;

	// configuration registers
	logic [4:0]           phase_count_q;
	logic [1:0]           loop_mode_q;
	logic [15:0]          loop_limit_q;
	logic [3:0]           first_phase_q;

	// sequencer state
	logic [AW-1:0]        phase_q;
	logic                 backward_q;
	logic [15:0]          loops_q;
	logic [TICK_BITS-1:0] elapsed_q;
	logic [TICK_BITS-1:0] length_q;
	logic                 changed_q;

	// phase table
	logic [DUR_W-1:0]     min_mem [MAX_PHASES];
	logic [DUR_W-1:0]     max_mem [MAX_PHASES];
	logic [DUR_W-1:0]     rd_min_q;
	logic [DUR_W-1:0]     rd_max_q;

	// remainder unit
	logic [DUR_W:0]       span_q;
	logic [DUR_W:0]       rem_q;
	logic [RND_W-1:0]     dvd_q;
	logic [DCW-1:0]       div_cnt_q;
	logic [DUR_W:0]       rem_nx;
	logic [RND_W-1:0]     dvd_nx;

	// derived control
	logic [CW-1:0]        cnt_use;
	logic [CW-1:0]        last_ph;
	logic [AW:0]          phase_inc;
	logic [TICK_BITS-1:0] elapsed_inc;
	logic                 at_last;
	logic                 halted_now;
	logic                 back_nx;
	logic [DUR_W-1:0]     len_sum;

	assign item_stall = (state_q != S_IDLE);
	assign cfg_ready  = 1'b1;

	// phases in use, clamped to the table size
	always_comb begin
		if (phase_count_q == 5'd0) begin
			cnt_use = CW'(1);
		end else if (32'(phase_count_q) > MAX_PHASES) begin
			cnt_use = CW'(MAX_PHASES);
		end else begin
			cnt_use = CW'(phase_count_q);
		end
	end

	assign last_ph     = cnt_use - 1'b1;
	assign phase_inc   = {1'b0, phase_q} + 1'b1;
	assign at_last     = (32'(phase_q) >= 32'(last_ph));
	assign halted_now  = (loop_mode_q == LOOP_COUNTED) && (loops_q >= loop_limit_q);
	assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;
	assign back_nx     = at_last ? 1'b1 : ((phase_q == '0) ? 1'b0 : backward_q);

	// one digit of the remainder: shift in dividend bits, subtract span when it fits
	always_comb begin
		logic [DUR_W+1:0] shifted;
		rem_nx = rem_q;
		dvd_nx = dvd_q;
		for (int i = 0; i < DIGIT_W; i++) begin
			shifted = {rem_nx, dvd_nx[RND_W-1]};
			dvd_nx  = {dvd_nx[RND_W-2:0], 1'b0};
			if (shifted >= {1'b0, span_q}) begin
				rem_nx = (DUR_W+1)'(shifted - {1'b0, span_q});
			end else begin
				rem_nx = (DUR_W+1)'(shifted);
			end
		end
	end

	assign len_sum = rd_min_q + rem_nx[DUR_W-1:0];

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_count_q <= 5'd1;
			loop_mode_q   <= LOOP_INFINITE;
			loop_limit_q  <= 16'd1;
			first_phase_q <= 4'd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PHASE_COUNT: phase_count_q <= cfg_data[4:0];
				REG_LOOP_MODE:   loop_mode_q   <= cfg_data[1:0];
				REG_LOOP_LIMIT:  loop_limit_q  <= cfg_data;
				REG_FIRST_PHASE: first_phase_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// phase table write on load, registered read of the phase being entered
	always_ff @(posedge clk) begin
		if (state_q == S_EXEC && item_q.mode == MODE_LOAD && 32'(item_q.slot) < MAX_PHASES) begin
			min_mem[AW'(item_q.slot)] <= item_q.min_ticks;
			max_mem[AW'(item_q.slot)] <= item_q.max_ticks;
		end
		rd_min_q <= min_mem[phase_q];
		rd_max_q <= max_mem[phase_q];
	end

	// item capture and remainder datapath
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && item_valid) begin
			item_q <= item;
		end
		if (state_q == S_SPAN) begin
			span_q <= {1'b0, rd_max_q} - {1'b0, rd_min_q} + 1'b1;
			rem_q  <= '0;
			dvd_q  <= item_q.random_value;
		end else if (state_q == S_DIV) begin
			rem_q <= rem_nx;
			dvd_q <= dvd_nx;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			phase_q      <= '0;
			backward_q   <= 1'b0;
			loops_q      <= '0;
			elapsed_q    <= '0;
			length_q     <= '0;
			changed_q    <= 1'b0;
			div_cnt_q    <= '0;
			result_valid <= 1'b0;
			result       <= '0;
		end else begin
			// drop valid once the result is taken, unless the final step refills it
			if (result_valid && !result_stall && state_q != S_FIN) begin
				result_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (item_q.mode)
						MODE_TICK: begin
							if (elapsed_inc < length_q || halted_now) begin
								// phase still running, or counting has halted
								elapsed_q <= elapsed_inc;
								changed_q <= 1'b0;
								state_q   <= S_FIN;
							end else begin
								changed_q <= 1'b1;
								state_q   <= S_READ;
								case (loop_mode_q)
									LOOP_PINGPONG: begin
										elapsed_q <= '0;
										if (cnt_use <= CW'(1)) begin
											phase_q <= '0;
										end else begin
											backward_q <= back_nx;
											phase_q    <= back_nx ? phase_q - 1'b1
											                      : phase_inc[AW-1:0];
										end
									end
									LOOP_COUNTED: begin
										elapsed_q <= '0;
										if (at_last) begin
											loops_q <= loops_q + 1'b1;
											phase_q <= '0;
										end else begin
											phase_q <= phase_inc[AW-1:0];
										end
									end
									default: begin
										elapsed_q <= elapsed_inc - length_q;
										phase_q   <= (32'(phase_inc) >= 32'(cnt_use))
										             ? '0 : phase_inc[AW-1:0];
									end
								endcase
							end
						end
						MODE_RESTART: begin
							backward_q <= 1'b0;
							loops_q    <= '0;
							elapsed_q  <= '0;
							changed_q  <= 1'b1;
							state_q    <= S_READ;
							phase_q    <= (32'(first_phase_q) < 32'(cnt_use))
							              ? AW'(first_phase_q) : '0;
						end
						default: begin
							changed_q <= 1'b0;
							state_q   <= S_FIN;
						end
					endcase
				end
				S_READ: begin
					state_q <= S_SPAN;
				end
				S_SPAN: begin
					if (rd_max_q > rd_min_q) begin
						div_cnt_q <= '0;
						state_q   <= S_DIV;
					end else begin
						length_q <= TICK_BITS'(rd_min_q);
						state_q  <= S_FIN;
					end
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == DCW'(DIV_STEPS - 1)) begin
						length_q <= TICK_BITS'(len_sum);
						state_q  <= S_FIN;
					end
				end
				S_FIN: begin
					// hand over once the output register is free
					if (!result_valid || !result_stall) begin
						result_valid         <= 1'b1;
						result.current_phase <= PHASE_W'(phase_q);
						result.phase_changed <= changed_q;
						result.halted        <= halted_now;
						state_q              <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// a new result only comes from the final step
	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q) == S_FIN)
		else $error("result raised outside final step");

	// phase index stays inside the table
	a_phase_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		32'(phase_q) < MAX_PHASES)
		else $error("phase index beyond table");

	// remainder stays below the span while iterating
	a_rem_below_span: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (rem_q < span_q))
		else $error("remainder not reduced");

	// restart clears the loop count and elapsed time
	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && item_q.mode == MODE_RESTART)
		|=> (loops_q == '0 && elapsed_q == '0 && !backward_q))
		else $error("restart left state behind");

endmodule

`default_nettype wire

// ===== verif/timed_phase_sequencer_checker.sv =====
// Checker for the timed phase sequencer: follows the register and item
// transfers, predicts each result and compares it with the block's output.
// Depends on tps_pkg.
`timescale 1ns / 1ps

module timed_phase_sequencer_checker
	import tps_pkg::*;
(
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 item_valid,
	input  wire                 item_stall,
	input  tps_item_t           item,
	input  wire                 result_valid,
	input  wire                 result_stall,
	input  tps_result_t         result,
	input  wire                 cfg_valid,
	input  wire                 cfg_ready,
	input  wire [CFG_IDX_W-1:0] cfg_index,
	input  wire [CFG_DAT_W-1:0] cfg_data,
	output int                  pending,
	output int                  fail_count
);

	localparam int SLOTS = 16;
	localparam int REPORT_LIMIT = 10;
	localparam logic [DUR_W-1:0] ELAPSED_TOP = '1;

	// predicted phase table and sequencer state
	logic [DUR_W-1:0]   lo_tab [SLOTS];
	logic [DUR_W-1:0]   hi_tab [SLOTS];
	logic [PHASE_W-1:0] seq_phase;
	logic               seq_back;
	logic [15:0]        seq_loops;
	logic [DUR_W-1:0]   seq_elapsed;
	logic [DUR_W-1:0]   seq_length;

	// register copies
	logic [4:0]         cfg_count;
	logic [1:0]         cfg_loop;
	logic [15:0]        cfg_limit;
	logic [3:0]         cfg_first;

	tps_result_t        phase_reports [$];
	int                 mismatches;

	// phase count clamped to the table size
	function automatic int unsigned phases_in_use();
		if (cfg_count == 5'd0) return 1;
		if (32'(cfg_count) > SLOTS) return SLOTS;
		return 32'(cfg_count);
	endfunction

	function automatic logic sequencer_halted();
		return cfg_loop == LOOP_COUNTED && seq_loops >= cfg_limit;
	endfunction

	// enter a phase and draw its length
	task automatic enter_phase(input int unsigned idx, input logic [RND_W-1:0] rnd);
		int unsigned lo;
		int unsigned hi;
		lo = 32'(lo_tab[idx]);
		hi = 32'(hi_tab[idx]);
		seq_phase = PHASE_W'(idx);
		if (hi > lo) seq_length = DUR_W'(lo + 32'(rnd) % (hi - lo + 1));
		else seq_length = DUR_W'(lo);
	endtask

	// one elapsed tick, advancing by the loop mode when the phase runs out
	task automatic take_tick(input logic [RND_W-1:0] rnd, output logic entered);
		int unsigned cnt;
		int unsigned cur;
		int unsigned nxt;
		cnt = phases_in_use();
		cur = 32'(seq_phase);
		entered = 1'b0;
		nxt = 0;
		if (seq_elapsed != ELAPSED_TOP) seq_elapsed = seq_elapsed + 1'b1;
		if (seq_elapsed < seq_length) return;
		case (cfg_loop)
			LOOP_PINGPONG: begin
				if (cnt > 1) begin
					if (cur >= cnt - 1) seq_back = 1'b1;
					else if (cur == 0) seq_back = 1'b0;
					nxt = seq_back ? cur - 1 : cur + 1;
				end
				seq_elapsed = '0;
			end
			LOOP_COUNTED: begin
				if (sequencer_halted()) return;
				if (cur >= cnt - 1) begin
					seq_loops = seq_loops + 1'b1;
					nxt = 0;
				end else begin
					nxt = cur + 1;
				end
				seq_elapsed = '0;
			end
			default: begin
				// infinite wrap, overshoot carried into the next phase
				nxt = cur + 1;
				if (nxt >= cnt) nxt = 0;
				seq_elapsed = seq_elapsed - seq_length;
			end
		endcase
		enter_phase(nxt, rnd);
		entered = 1'b1;
	endtask

	// apply one item and work out its result
	task automatic step_sequencer(input tps_item_t it, output tps_result_t r);
		logic entered;
		int unsigned start;
		entered = 1'b0;
		case (it.mode)
			MODE_TICK: take_tick(it.random_value, entered);
			MODE_LOAD: begin
				lo_tab[it.slot] = it.min_ticks;
				hi_tab[it.slot] = it.max_ticks;
			end
			MODE_RESTART: begin
				start = (32'(cfg_first) < phases_in_use()) ? 32'(cfg_first) : 0;
				seq_back = 1'b0;
				seq_loops = '0;
				seq_elapsed = '0;
				enter_phase(start, it.random_value);
				entered = 1'b1;
			end
			default: ;
		endcase
		r.current_phase = seq_phase;
		r.phase_changed = entered;
		r.halted = sequencer_halted();
	endtask

	// follow transfers, predict and compare
	always @(posedge clk or negedge arst_n) begin
		tps_result_t due;
		tps_result_t predicted;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				lo_tab[i] = '0;
				hi_tab[i] = '0;
			end
			seq_phase = '0;
			seq_back = 1'b0;
			seq_loops = '0;
			seq_elapsed = '0;
			seq_length = '0;
			cfg_count = 5'd1;
			cfg_loop = LOOP_INFINITE;
			cfg_limit = 16'd1;
			cfg_first = '0;
			phase_reports.delete();
			mismatches = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_PHASE_COUNT: cfg_count = cfg_data[4:0];
					REG_LOOP_MODE:   cfg_loop = cfg_data[1:0];
					REG_LOOP_LIMIT:  cfg_limit = cfg_data[15:0];
					REG_FIRST_PHASE: cfg_first = cfg_data[3:0];
					default: ;
				endcase
			end
			if (result_valid && !result_stall) begin
				if (phase_reports.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("unexpected result: phase %0d changed %0b halted %0b",
							result.current_phase, result.phase_changed, result.halted);
				end else begin
					due = phase_reports.pop_front();
					if (due.current_phase != result.current_phase ||
							due.phase_changed != result.phase_changed ||
							due.halted != result.halted) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT)
							$display({"mismatch: expected phase %0d changed %0b halted %0b,",
								" got phase %0d changed %0b halted %0b"},
								due.current_phase, due.phase_changed, due.halted,
								result.current_phase, result.phase_changed, result.halted);
					end
				end
			end
			if (item_valid && !item_stall) begin
				step_sequencer(item, predicted);
				phase_reports.push_back(predicted);
			end
		end
		pending = phase_reports.size();
		fail_count = mismatches;
	end

endmodule

// ===== verif/timed_phase_sequencer_top_tb.sv =====
// Testbench top for the timed phase sequencer: clock, reset, register
// writes, item and stall stimulus, and the final verdict.
// Depends on tps_pkg, timed_phase_sequencer_top and timed_phase_sequencer_checker.
`timescale 1ns / 1ps

module timed_phase_sequencer_top_tb;
	import tps_pkg::*;

	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam logic [1:0] LOOP_SPARE = 2'd3;
	localparam longint CYCLE_LIMIT = 4_000_000;
	localparam int DRAIN_CYCLES = 20;
	localparam int SOAK_TICKS = 40;
	localparam int SETTINGS_RUN = 9;
	localparam int ITEMS_PER_SETTING = 45;

	logic                 clk;
	logic                 arst_n;
	logic                 item_valid;
	logic                 item_stall;
	tps_item_t            item;
	logic                 result_valid;
	logic                 result_stall;
	tps_result_t          result;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;
	int                   pending;
	int                   fail_count;
	bit                   gaps_on;
	longint               cycles;

	timed_phase_sequencer_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	timed_phase_sequencer_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pending      (pending),
		.fail_count   (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run guard
	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// random back-pressure on the result side
	initial begin
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			result_stall = gaps_on && ($urandom_range(99) < 22);
		end
	end

	// fully random payload, the mode is set by the callers
	function automatic tps_item_t noise_item();
		tps_item_t it;
		it.mode = MODE_W'($urandom_range(3));
		it.slot = SLOT_W'($urandom_range(15));
		it.min_ticks = DUR_W'($urandom);
		it.max_ticks = DUR_W'($urandom);
		it.random_value = RND_W'($urandom);
		return it;
	endfunction

	function automatic tps_item_t with_mode(input logic [MODE_W-1:0] m);
		tps_item_t it;
		it = noise_item();
		it.mode = m;
		return it;
	endfunction

	function automatic tps_item_t load_item(input int s, input int lo, input int hi);
		tps_item_t it;
		it = with_mode(MODE_LOAD);
		it.slot = SLOT_W'(s);
		it.min_ticks = DUR_W'(lo);
		it.max_ticks = DUR_W'(hi);
		return it;
	endfunction

	// mostly short durations so phases keep turning over
	function automatic tps_item_t random_load();
		int d;
		int lo;
		int hi;
		d = $urandom_range(99);
		if (d < 70) begin
			lo = $urandom_range(5);
			hi = lo + $urandom_range(6);
		end else if (d < 88) begin
			lo = $urandom_range(8, 1);
			hi = $urandom_range(lo - 1);
		end else if (d < 96) begin
			lo = $urandom_range(3);
			hi = lo;
		end else begin
			lo = $urandom_range(65535);
			hi = $urandom_range(65535);
		end
		return load_item($urandom_range(15), lo, hi);
	endfunction

	function automatic tps_item_t random_item();
		int pick;
		pick = $urandom_range(99);
		if (pick < 76) return with_mode(MODE_TICK);
		if (pick < 88) return random_load();
		if (pick < 95) return with_mode(MODE_RESTART);
		return with_mode(MODE_UNUSED);
	endfunction

	// one item transfer, with random gaps ahead of it
	task automatic send_item(input tps_item_t it);
		while (gaps_on && $urandom_range(99) < 22) begin
			item_valid = 1'b0;
			@(negedge clk);
		end
		item_valid = 1'b1;
		item = it;
		do @(posedge clk); while (item_stall);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// let every outstanding result come back
	task automatic wait_quiet();
		item_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic apply_setting(input int cnt, input logic [1:0] loop, input int limit,
			input int first);
		wait_quiet();
		write_reg(REG_PHASE_COUNT, CFG_DAT_W'(cnt));
		write_reg(REG_LOOP_MODE, CFG_DAT_W'(loop));
		write_reg(REG_LOOP_LIMIT, CFG_DAT_W'(limit));
		write_reg(REG_FIRST_PHASE, CFG_DAT_W'(first));
	endtask

	initial begin
		int         set_count [SETTINGS_RUN];
		logic [1:0] set_loop  [SETTINGS_RUN];
		int         set_limit [SETTINGS_RUN];
		int         set_first [SETTINGS_RUN];
		int         lo;

		set_count = '{4, 16, 1, 3, 16, 3, 0, 31, 1};
		set_loop  = '{LOOP_INFINITE, LOOP_PINGPONG, LOOP_PINGPONG, LOOP_COUNTED,
			LOOP_COUNTED, LOOP_SPARE, LOOP_PINGPONG, LOOP_INFINITE, LOOP_INFINITE};
		set_limit = '{1, 0, 5, 2, 65535, 0, 1, 3, 1};
		set_first = '{1, 15, 0, 2, 15, 7, 0, 9, 0};
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		gaps_on = 1'b1;
		set_count[SETTINGS_RUN-1] = $urandom_range(16, 1);
		set_loop[SETTINGS_RUN-1] = 2'($urandom_range(3));
		set_limit[SETTINGS_RUN-1] = $urandom_range(4);
		set_first[SETTINGS_RUN-1] = $urandom_range(15);
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: fill the table, with extreme entries in slots 0 and 13 to 15, then exercise phase 0
		for (int s = 0; s < 16; s++) begin
			case (s)
				0:  send_item(load_item(s, 3, 1));        // max below min
				13: send_item(load_item(s, 0, 0));
				14: send_item(load_item(s, 0, 65535));
				15: send_item(load_item(s, 65535, 65535));
				default: send_item(load_item(s, s % 3, s % 3 + 4));
			endcase
		end
		repeat (4) send_item(with_mode(MODE_TICK));
		send_item(with_mode(MODE_UNUSED));
		send_item(with_mode(MODE_RESTART));
		send_item(with_mode(MODE_TICK));
		send_item(load_item(0, 0, 0));
		repeat (3) send_item(with_mode(MODE_TICK));

		// random: short durations everywhere, then a run per setting
		for (int s = 0; s < 16; s++) begin
			lo = $urandom_range(4);
			send_item(load_item(s, lo, lo + $urandom_range(4)));
		end
		for (int k = 0; k < SETTINGS_RUN; k++) begin
			apply_setting(set_count[k], set_loop[k], set_limit[k], set_first[k]);
			gaps_on = (k != 4);
			send_item(with_mode(MODE_RESTART));
			repeat (ITEMS_PER_SETTING) send_item(random_item());
		end

		// halted counting keeps the elapsed time growing, then release it into wrap
		apply_setting(4, LOOP_COUNTED, 0, 0);
		gaps_on = 1'b0;
		send_item(with_mode(MODE_RESTART));
		repeat (SOAK_TICKS) send_item(with_mode(MODE_TICK));
		gaps_on = 1'b1;
		wait_quiet();
		write_reg(REG_LOOP_MODE, CFG_DAT_W'(LOOP_INFINITE));
		repeat (40) send_item(with_mode(MODE_TICK));

		wait_quiet();
		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
